[hw/rtl/srtl_pkg.sv]
// package: types, constants and codes shared by the sorted array list block
package srtl_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_SORTED = 3'd0,
		OP_INS_POS    = 3'd1,
		OP_DELETE     = 3'd2,
		OP_SEARCH     = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_LOAD  = 2'd1,
		S_SCAN  = 2'd2,
		S_WRITE = 2'd3
	} state_t;

	// request payload
	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        position;
	} req_t;

	// result payload
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
	} rsp_t;

	// broadcast command from the controller to every cell
	typedef struct packed {
		logic                    load_eq;
		logic                    load_le;
		logic                    shift;
		logic                    ins;
		logic                    del;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        pos;
	} cell_cmd_t;

endpackage

[hw/rtl/srtl_cell.sv]
// one list cell: holds one key and one compare flag, trades with its neighbors
module srtl_cell import srtl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CNT_W-1:0]        cell_idx,
	input  cell_cmd_t               cmd,
	input  logic signed [KEY_W-1:0] left_entry,
	input  logic signed [KEY_W-1:0] right_entry,
	input  logic                    right_flag,
	output logic signed [KEY_W-1:0] entry,
	output logic                    flag
);

	logic signed [KEY_W-1:0] entry_q;
	logic                    flag_q;

	// compare flag: loaded from the key compare, then walks toward cell zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd.load_eq) begin
			flag_q <= ($signed(entry_q) == $signed(cmd.key));
		end else if (cmd.load_le) begin
			flag_q <= ($signed(entry_q) <= $signed(cmd.key));
		end else if (cmd.shift) begin
			flag_q <= right_flag;
		end
	end

	// stored key: shift up on insert, shift down on delete
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (cell_idx > cmd.pos) begin
				entry_q <= left_entry;
			end else if (cell_idx == cmd.pos) begin
				entry_q <= cmd.key;
			end
		end else if (cmd.del) begin
			if (cell_idx >= cmd.pos) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry = entry_q;
	assign flag  = flag_q;

endmodule

[hw/rtl/srtl_ctrl.sv]
// controller: request decode, flag walk over the chain, count and result
module srtl_ctrl import srtl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_t      req,
	input  logic      head_flag,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp,
	output cell_cmd_t cmd
);

	state_t                  state_q, state_d;
	op_t                     op_q, op_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [CNT_W-1:0]        pos_q, pos_d;
	logic [CNT_W-1:0]        step_q, step_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic                    done_q, done_d;
	rsp_t                    rsp_q, rsp_d;
	logic                    full;

	assign full = (count_q == CNT_W'(CAPACITY));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		key_q  <= key_d;
		pos_q  <= pos_d;
		step_q <= step_d;
		rsp_q  <= rsp_d;
	end

	// next state, cell commands and result
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		key_d       = key_q;
		pos_d       = pos_q;
		step_d      = step_q;
		count_d     = count_q;
		done_d      = 1'b0;
		rsp_d       = rsp_q;
		cmd         = '0;
		cmd.key     = key_q;
		cmd.pos     = pos_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d   = op_t'(req.operation);
					key_d  = req.key;
					pos_d  = '0;
					step_d = '0;
					case (req.operation)
						OP_INS_SORTED: begin
							if (full) begin
								done_d = 1'b1;
								rsp_d  = '{status: ST_FULL, index: '0, count: count_q};
							end else begin
								state_d = S_LOAD;
							end
						end
						OP_INS_POS: begin
							if (full) begin
								done_d = 1'b1;
								rsp_d  = '{status: ST_FULL, index: '0, count: count_q};
							end else if (req.position > count_q) begin
								done_d = 1'b1;
								rsp_d  = '{status: ST_BADPOS, index: '0, count: count_q};
							end else begin
								pos_d   = req.position;
								state_d = S_WRITE;
							end
						end
						OP_DELETE, OP_SEARCH: begin
							state_d = S_LOAD;
						end
						OP_CLEAR: begin
							count_d = '0;
							done_d  = 1'b1;
							rsp_d   = '{status: ST_OK, index: '0, count: '0};
						end
						default: begin
							done_d = 1'b1;
							rsp_d  = '{status: ST_OK, index: '0, count: count_q};
						end
					endcase
				end
			end
			S_LOAD: begin
				cmd.load_le = (op_q == OP_INS_SORTED);
				cmd.load_eq = (op_q != OP_INS_SORTED);
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				if (step_q == count_q) begin
					// walked every stored key
					if (op_q == OP_INS_SORTED) begin
						state_d = S_WRITE;
					end else begin
						state_d = S_IDLE;
						done_d  = 1'b1;
						rsp_d   = '{status: ST_NOTFOUND, index: '0, count: count_q};
					end
				end else begin
					cmd.shift = 1'b1;
					step_d    = step_q + 1'b1;
					if (op_q == OP_INS_SORTED) begin
						// remember the slot after the last key not above the new one
						if (head_flag) begin
							pos_d = step_q + 1'b1;
						end
					end else if (head_flag) begin
						pos_d = step_q;
						if (op_q == OP_SEARCH) begin
							state_d = S_IDLE;
							done_d  = 1'b1;
							rsp_d   = '{status: ST_OK, index: step_q[IDX_W-1:0],
								count: count_q};
						end else begin
							state_d = S_WRITE;
						end
					end
				end
			end
			S_WRITE: begin
				if (op_q == OP_DELETE) begin
					cmd.del = 1'b1;
					count_d = count_q - 1'b1;
				end else begin
					cmd.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
				state_d = S_IDLE;
				done_d  = 1'b1;
				rsp_d   = '{status: ST_OK, index: pos_q[IDX_W-1:0], count: count_d};
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hw/rtl/sorted_array_list_top.sv]
// top level: controller plus the chain of list cells
//
//  channel   signals            direction  accepted when
//  request   start, busy, req   in         start && !busy at a rising edge
//  result    done, rsp          out        the cycle done is high
//
// clear, unused codes, full and bad position: result in the cycle after accept
// insert at position: result registered from the write state
// search, delete, insert sorted: load and scan states, then write for a change; the scan
//   is the flag walk that moves one compare flag per cycle down the cell chain to the controller
// reset clears the count and the controller; stored keys are never cleared
// the receiver cannot stall; busy is low again in the cycle done is high
module sorted_array_list_top import srtl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cell_cmd_t               cmd;
	logic signed [KEY_W-1:0] ent   [CAPACITY];
	logic                    flg   [CAPACITY];
	logic signed [KEY_W-1:0] left  [CAPACITY];
	logic signed [KEY_W-1:0] right [CAPACITY];
	logic                    rflg  [CAPACITY];

	// controller
	srtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.head_flag (flg[0]),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cmd       (cmd)
	);

	// cell chain with neighbor links
	for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
		if (i == 0) begin : g_first
			assign left[i] = cmd.key;
		end else begin : g_mid_l
			assign left[i] = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right[i] = ent[i];
			assign rflg[i]  = 1'b0;
		end else begin : g_mid_r
			assign right[i] = ent[i+1];
			assign rflg[i]  = flg[i+1];
		end

		srtl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (CNT_W'(i)),
			.cmd         (cmd),
			.left_entry  (left[i]),
			.right_entry (right[i]),
			.right_flag  (rflg[i]),
			.entry       (ent[i]),
			.flag        (flg[i])
		);
	end

endmodule

[hw/rtl/srtl_chk.sv]
// port checker for the sorted array list, bound to the top level
module srtl_chk import srtl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// count never exceeds capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.count <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	// full status only with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> rsp.count == CNT_W'(CAPACITY))
		else $error("full reported with room left");

	// every failure reports index zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.index == '0)
		else $error("nonzero index on failure");

	// clear answers in the next cycle with an empty list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == OP_CLEAR) |=> (done && rsp.count == '0))
		else $error("clear did not empty the list");

endmodule

bind sorted_array_list_top srtl_chk u_chk (.*);

[tb/sv/tb.sv]
// testbench for the sorted array list: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb;

	import srtl_pkg::*;

	localparam int          LIMIT_CYCLES = 1_500_000;
	localparam int          TAIL_CYCLES  = 2 * CAPACITY + 16;
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          POS_MAX      = (1 << CNT_W) - 1;
	localparam int          OP_CODES     = 1 << OP_W;
	localparam int          POOL_DEPTH   = 96;
	localparam int          PRINT_CAP    = 40;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

	// one pending request with the idle time in front of it
	typedef struct {
		req_t        r;
		bit          drain;
		int unsigned gap;
	} job_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	job_t op_backlog[$];
	rsp_t rsp_expected[$];
	logic signed [KEY_W-1:0] key_pool[$];

	// predictor copy of the list
	logic signed [KEY_W-1:0] list_model[CAPACITY];
	int fill_model = 0;

	int          n_accepted = 0;
	int          n_results  = 0;
	int          n_errors   = 0;
	int          st_seen[4] = '{default: 0};
	int unsigned idle_left  = 0;
	int unsigned cycle_count = 0;
	bit          drain_next = 1'b0;
	bit          no_idle    = 1'b0;

	sorted_array_list_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one request to the predictor copy and return the result it should give
	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int j;
		int hit;
		logic signed [KEY_W-1:0] k;
		o = '0;
		k = r.key;
		hit = -1;
		if (r.operation == OP_DELETE || r.operation == OP_SEARCH) begin
			for (int i = 0; i < fill_model && hit < 0; i++)
				if (list_model[i] == k)
					hit = i;
		end
		case (r.operation)
			OP_INS_SORTED: begin
				if (fill_model >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					j = fill_model;
					while (j > 0 && list_model[j-1] > k) begin
						list_model[j] = list_model[j-1];
						j--;
					end
					list_model[j] = k;
					fill_model++;
					o.index = IDX_W'(j);
				end
			end
			OP_INS_POS: begin
				if (fill_model >= CAPACITY) begin
					o.status = ST_FULL;
				end else if (int'(r.position) > fill_model) begin
					o.status = ST_BADPOS;
				end else begin
					for (j = fill_model; j > int'(r.position); j--)
						list_model[j] = list_model[j-1];
					list_model[r.position] = k;
					fill_model++;
					o.index = IDX_W'(r.position);
				end
			end
			OP_DELETE: begin
				if (hit < 0) begin
					o.status = ST_NOTFOUND;
				end else begin
					for (j = hit; j + 1 < fill_model; j++)
						list_model[j] = list_model[j+1];
					fill_model--;
					o.index = IDX_W'(hit);
				end
			end
			OP_SEARCH: begin
				if (hit < 0)
					o.status = ST_NOTFOUND;
				else
					o.index = IDX_W'(hit);
			end
			OP_CLEAR: begin
				fill_model = 0;
			end
			default: begin
			end
		endcase
		o.count = CNT_W'(fill_model);
		return o;
	endfunction

	// idle cycles before a request: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// keys: extremes, a narrow band for duplicates, or anything
	function automatic logic signed [KEY_W-1:0] draw_key();
		int v;
		case ($urandom_range(0, 9))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2, 3, 4: begin
				v = $urandom_range(0, 16);
				return v - 8;
			end
			default: return $urandom;
		endcase
	endfunction

	// keys for delete and search: mostly ones inserted earlier
	function automatic logic signed [KEY_W-1:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return draw_key();
	endfunction

	task automatic add_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k, int p);
		job_t jb;
		jb.r.operation = op;
		jb.r.key       = k;
		jb.r.position  = CNT_W'(p);
		jb.drain       = drain_next;
		jb.gap         = pick_gap();
		drain_next     = 1'b0;
		op_backlog.push_back(jb);
		if (op == OP_INS_SORTED || op == OP_INS_POS) begin
			key_pool.push_back(k);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end
	endtask

	// clear, fill with known count, overflow if filled to capacity, then look up and remove
	task automatic gen_fill(bit fill_all);
		int n;
		n = (!fill_all && $urandom_range(0, 3) == 0) ? $urandom_range(1, CAPACITY - 1) :
			CAPACITY;
		drain_next = 1'b1;
		add_op(OP_CLEAR, draw_key(), $urandom_range(0, POS_MAX));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				add_op(OP_INS_SORTED, draw_key(), $urandom_range(0, POS_MAX));
			else
				add_op(OP_INS_POS, draw_key(), $urandom_range(0, i));
		end
		if (n == CAPACITY) begin
			repeat ($urandom_range(1, 3))
				add_op($urandom_range(0, 1) ? OP_INS_SORTED : OP_INS_POS, draw_key(),
					$urandom_range(0, POS_MAX));
		end
		repeat ($urandom_range(4, 20))
			add_op($urandom_range(0, 1) ? OP_SEARCH : OP_DELETE, pick_key(),
				$urandom_range(0, POS_MAX));
	endtask

	// weighted mix of all operations on whatever the list holds
	task automatic gen_mixed();
		int w;
		int p;
		repeat ($urandom_range(20, 40)) begin
			w = $urandom_range(0, 99);
			p = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(0, POS_MAX);
			if (w < 25)
				add_op(OP_INS_SORTED, draw_key(), p);
			else if (w < 45)
				add_op(OP_INS_POS, draw_key(), p);
			else if (w < 70)
				add_op(OP_DELETE, pick_key(), p);
			else if (w < 90)
				add_op(OP_SEARCH, pick_key(), p);
			else if (w < 93)
				add_op(OP_CLEAR, draw_key(), p);
			else
				add_op(OP_W'($urandom_range(0, OP_CODES - 1)), draw_key(), p);
		end
	endtask

	task automatic build_stimulus();
		int phase;
		// directed: empty list, extremes, duplicates, positions, unused codes
		add_op(OP_CLEAR, '0, 0);
		add_op(OP_SEARCH, 5, 0);
		add_op(OP_DELETE, 5, 0);
		add_op(OP_INS_POS, 7, 1);
		add_op(OP_INS_SORTED, KEY_MAX, 0);
		add_op(OP_INS_SORTED, KEY_MIN, 0);
		add_op(OP_INS_SORTED, 0, 0);
		add_op(OP_INS_SORTED, 0, 0);
		add_op(OP_INS_SORTED, -1, 0);
		add_op(OP_INS_POS, 42, 0);
		add_op(OP_INS_POS, 43, 6);
		add_op(OP_INS_POS, 44, 8);
		add_op(OP_INS_POS, 45, POS_MAX);
		add_op(OP_INS_POS, 46, CAPACITY);
		add_op(OP_SEARCH, 0, 0);
		add_op(OP_SEARCH, KEY_MAX, 0);
		add_op(OP_DELETE, KEY_MIN, 0);
		add_op(OP_DELETE, 0, 0);
		add_op(OP_DELETE, 12345, 0);
		for (int c = OP_CLEAR + 1; c < OP_CODES; c++)
			add_op(OP_W'(c), KEY_MAX, POS_MAX);
		add_op(OP_CLEAR, KEY_MIN, POS_MAX);
		add_op(OP_SEARCH, 0, 0);
		// random phases, the first one always fills the list to capacity
		gen_fill(1'b1);
		while (op_backlog.size() < RANDOM_ITEMS + 24) begin
			no_idle = ($urandom_range(0, 3) == 0);
			phase = $urandom_range(0, 99);
			if (phase < 40) begin
				gen_fill(1'b0);
			end else if (phase < 75) begin
				gen_mixed();
			end else if (phase < 90) begin
				repeat ($urandom_range(10, CAPACITY))
					add_op(OP_DELETE, pick_key(), $urandom_range(0, POS_MAX));
			end else begin
				repeat (5)
					add_op(OP_W'($urandom_range(0, OP_CODES - 1)), draw_key(),
						$urandom_range(0, POS_MAX));
			end
		end
		no_idle = 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		req_t        nxt_req;
		logic        nxt_start;
		int unsigned nxt_idle;
		if (!arst_n) begin
			start     <= 1'b0;
			req       <= '0;
			idle_left <= 0;
		end else begin
			nxt_req   = req;
			nxt_start = start;
			nxt_idle  = idle_left;
			if (start && !busy) begin
				rsp_expected.push_back(list_apply(req));
				n_accepted++;
				nxt_start = 1'b0;
				nxt_idle  = (op_backlog.size() > 0) ? op_backlog[0].gap : 0;
			end
			if (!nxt_start && op_backlog.size() > 0) begin
				if (op_backlog[0].drain && rsp_expected.size() > 0) begin
					// hold off until every outstanding result is back
				end else if (nxt_idle > 0) begin
					nxt_idle--;
				end else begin
					nxt_req   = op_backlog[0].r;
					nxt_start = 1'b1;
					void'(op_backlog.pop_front());
				end
			end
			start     <= nxt_start;
			req       <= nxt_req;
			idle_left <= nxt_idle;
		end
	end

	task automatic report_mismatch(string msg);
		// keep the log short when something is badly broken
		if (n_errors < PRINT_CAP)
			$display("mismatch: %s", msg);
		n_errors++;
	endtask

	// result monitor, sampled mid-cycle while the strobe is stable
	always @(negedge clk) begin : watch_results
		rsp_t e;
		if (arst_n && done) begin
			if (rsp_expected.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request outstanding: %0d/%0d/%0d",
					n_results, rsp.status, rsp.index, rsp.count));
			end else begin
				e = rsp_expected.pop_front();
				st_seen[e.status]++;
				if (rsp.status !== e.status)
					report_mismatch($sformatf("result %0d: status %0d, expected %0d",
						n_results, rsp.status, e.status));
				if (rsp.index !== e.index)
					report_mismatch($sformatf("result %0d: index %0d, expected %0d",
						n_results, rsp.index, e.index));
				if (rsp.count !== e.count)
					report_mismatch($sformatf("result %0d: count %0d, expected %0d",
						n_results, rsp.count, e.count));
			end
			n_results++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, rsp_expected.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// main sequence
	initial begin
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (op_backlog.size() > 0 || start || rsp_expected.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (rsp_expected.size() > 0)
			report_mismatch($sformatf("%0d results never arrived", rsp_expected.size()));
		$display("summary: %0d requests accepted, %0d results checked, %0d mismatches",
			n_accepted, n_results, n_errors);
		$display("summary: ok %0d, full %0d, bad position %0d, not found %0d",
			st_seen[ST_OK], st_seen[ST_FULL], st_seen[ST_BADPOS], st_seen[ST_NOTFOUND]);
		if (n_errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
